@@ rtl/wsr_pkg.sv @@
// Shared types and constants of the windowed-sinc sample rate converter.
package wsr_pkg;

    localparam int RATE_W      = 24;
    localparam int SAMPLE_W    = 16;
    localparam int T_W         = 40;
    localparam int CUT_W       = 17;
    localparam int FRAC_W      = 16;
    localparam int TAB_IDX_W   = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_OUTPUTS = 64;
    localparam int OUT_CNT_W   = 6;
    localparam int UPSAMPLE_SH = 6;
    localparam int RND_BIAS    = 127;

    localparam logic [RATE_W-1:0]    RATE_RESET = 24'd48000;
    localparam logic [CUT_W-1:0]     UNIT_ONE   = 17'h10000;
    localparam logic                 OP_LOAD    = 1'b0;
    localparam logic                 OP_PUSH    = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = 2'd1;

    typedef struct packed {
        logic cfg_write;
        logic tab_write;
        logic push;
        logic div_start;
        logic div_sel;
        logic cut_cap;
        logic tout_cap;
        logic p_mul;
        logic p_load;
        logic dir_fwd;
        logic tap_issue;
        logic acc_clear;
        logic rnd;
        logic scale;
        logic emit;
        logic last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic t_lt_period;
        logic p_ok;
        logic pipe_empty;
        logic out_free;
        logic tnext_lt;
    } dp_status_t;

endpackage

@@ rtl/windowed_sinc_resampler.sv @@
// Top level of the windowed-sinc sample rate converter.
//
// Usage: write input_rate (index 0) and output_rate (index 1) on the cfg channel while the
// block is idle; a write of zero, to another index, or one giving more than 64 output
// samples per input sample is dropped. After every cfg beat, and after reset, the block
// spends two serial divisions deriving the cutoff and output period; no item
// is taken meanwhile. On the input channel a beat with operation clear loads
// one filter table entry and is absorbed in the same cycle. A beat with operation
// set pushes a sample; it yields zero or more output beats, the last of
// them flagged by last_of_run. For each output the taps go one per
// cycle through a single interpolate-and-multiply-accumulate pipeline fed by the history
// ring and filter table memories, followed by rounding, cutoff scaling and saturation.
// The next input beat is taken once the last result of a push sits in the output
// register, so a waiting result does not hold up the input side; if the receiver stalls
// the output, the following result waits inside the block and the input stays stalled.
// Reset clears the history to zeros, sets both rates to 48000 and the phase to its start;
// the filter table holds nothing until loaded and must be filled before samples are pushed.
module windowed_sinc_resampler #(
    parameter int HALF_TAPS           = 32,
    parameter int PHASES_PER_CROSSING = 256,
    parameter int ZERO_CROSSINGS      = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wsr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wsr_pkg::RATE_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [wsr_pkg::TAB_IDX_W-1:0]       table_index,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] coef_base,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] coef_slope,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [wsr_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                last_of_run
);

    wsr_pkg::ctrl_cmd_t  cmd;
    wsr_pkg::dp_status_t status;

    // The controller decides what happens each cycle; the datapath only obeys commands.
    wsr_ctrl #(
        .HALF_TAPS (HALF_TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .status    (status)
    );

    wsr_datapath #(
        .HALF_TAPS           (HALF_TAPS),
        .PHASES_PER_CROSSING (PHASES_PER_CROSSING),
        .ZERO_CROSSINGS      (ZERO_CROSSINGS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .table_index (table_index),
        .coef_base   (coef_base),
        .coef_slope  (coef_slope),
        .sample_in   (sample_in),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .sample_out  (sample_out),
        .last_of_run (last_of_run)
    );

    // A cfg beat and an input beat are never taken in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && in_valid && !in_stall))
        else $error("cfg and input beats accepted together");

    // A table load leaves the block idle, so only a pending cfg beat can stall the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (operation == wsr_pkg::OP_LOAD)) |=>
        (in_stall == cfg_valid))
        else $error("table load did not return to idle");

    // A pushed sample occupies the block: both input and cfg are held off next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (operation == wsr_pkg::OP_PUSH)) |=>
        (in_stall && !cfg_ready))
        else $error("block not busy after sample push");

endmodule

@@ rtl/wsr_ram.sv @@
// Generic simple dual-port RAM with registered read.
module wsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/wsr_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module wsr_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den};
        ge        = trial >= {1'b0, den};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

@@ rtl/wsr_ctrl.sv @@
// Controller state machine: sequences rate set-up, tap walks and result hand-off.
module wsr_ctrl #(
    parameter int HALF_TAPS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   operation,
    output logic                   in_stall,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    output wsr_pkg::ctrl_cmd_t     cmd,
    input  wsr_pkg::dp_status_t    status
);

    localparam int CNT_W = $clog2(HALF_TAPS + 2);

    localparam logic [3:0] S_DIV_CUT   = 4'd0;
    localparam logic [3:0] S_WAIT_CUT  = 4'd1;
    localparam logic [3:0] S_DIV_TOUT  = 4'd2;
    localparam logic [3:0] S_WAIT_TOUT = 4'd3;
    localparam logic [3:0] S_IDLE      = 4'd4;
    localparam logic [3:0] S_CHECK     = 4'd5;
    localparam logic [3:0] S_MUL_B     = 4'd6;
    localparam logic [3:0] S_LOAD_B    = 4'd7;
    localparam logic [3:0] S_BACK      = 4'd8;
    localparam logic [3:0] S_MUL_F     = 4'd9;
    localparam logic [3:0] S_LOAD_F    = 4'd10;
    localparam logic [3:0] S_FWD       = 4'd11;
    localparam logic [3:0] S_DRAIN     = 4'd12;
    localparam logic [3:0] S_RND       = 4'd13;
    localparam logic [3:0] S_SCALE     = 4'd14;
    localparam logic [3:0] S_EMIT      = 4'd15;

    logic [3:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [wsr_pkg::OUT_CNT_W-1:0]  nout_reg, nout_next;
    logic                           in_acc;
    logic                           last;

    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign last      = !(status.tnext_lt &&
                         (nout_reg != wsr_pkg::OUT_CNT_W'(wsr_pkg::MAX_OUTPUTS - 1)));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        nout_next  = nout_reg;
        cmd        = '0;
        case (state_reg)
            S_DIV_CUT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_CUT;
            end
            S_WAIT_CUT:
            begin
                if (!status.div_busy)
                begin
                    cmd.cut_cap = 1'b1;
                    state_next  = S_DIV_TOUT;
                end
            end
            S_DIV_TOUT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = S_WAIT_TOUT;
            end
            S_WAIT_TOUT:
            begin
                cmd.div_sel = 1'b1;
                if (!status.div_busy)
                begin
                    cmd.tout_cap = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_write = 1'b1;
                    state_next    = S_DIV_CUT;
                end
                else if (in_acc)
                begin
                    if (operation == wsr_pkg::OP_PUSH)
                    begin
                        cmd.push   = 1'b1;
                        nout_next  = '0;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        cmd.tab_write = 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                state_next = status.t_lt_period ? S_MUL_B : S_IDLE;
            end
            S_MUL_B:
            begin
                cmd.p_mul     = 1'b1;
                cmd.acc_clear = 1'b1;
                state_next    = S_LOAD_B;
            end
            S_LOAD_B:
            begin
                cmd.p_load = 1'b1;
                cnt_next   = CNT_W'(HALF_TAPS + 1);
                state_next = S_BACK;
            end
            S_BACK:
            begin
                if (status.p_ok && (cnt_reg != '0))
                begin
                    cmd.tap_issue = 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = S_MUL_F;
                end
            end
            S_MUL_F:
            begin
                cmd.p_mul   = 1'b1;
                cmd.dir_fwd = 1'b1;
                state_next  = S_LOAD_F;
            end
            S_LOAD_F:
            begin
                cmd.p_load  = 1'b1;
                cmd.dir_fwd = 1'b1;
                cnt_next    = CNT_W'(HALF_TAPS);
                state_next  = S_FWD;
            end
            S_FWD:
            begin
                cmd.dir_fwd = 1'b1;
                if (status.p_ok && (cnt_reg != '0))
                begin
                    cmd.tap_issue = 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = last;
                    nout_next  = nout_reg + 1'b1;
                    state_next = last ? S_IDLE : S_MUL_B;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_DIV_CUT;
            cnt_reg   <= '0;
            nout_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            nout_reg  <= nout_next;
        end
    end

endmodule

@@ rtl/wsr_datapath.sv @@
// Datapath: rate registers, history ring, filter table, tap pipeline and output register.
module wsr_datapath #(
    parameter int HALF_TAPS           = 32,
    parameter int PHASES_PER_CROSSING = 256,
    parameter int ZERO_CROSSINGS      = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wsr_pkg::ctrl_cmd_t                    cmd,
    output wsr_pkg::dp_status_t                   status,
    input  logic [wsr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wsr_pkg::RATE_W-1:0]            cfg_data,
    input  logic [wsr_pkg::TAB_IDX_W-1:0]         table_index,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0]   coef_base,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0]   coef_slope,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic signed [wsr_pkg::SAMPLE_W-1:0]   sample_out,
    output logic                                  last_of_run
);

    localparam int SW          = wsr_pkg::SAMPLE_W;
    localparam int RW          = wsr_pkg::RATE_W;
    localparam int TW          = wsr_pkg::T_W;
    localparam int CW          = wsr_pkg::CUT_W;
    localparam int RING_DEPTH  = 2 * HALF_TAPS + 1;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int TABLE_DEPTH = ZERO_CROSSINGS * PHASES_PER_CROSSING + 1;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int PPC_W       = $clog2(PHASES_PER_CROSSING + 1);
    localparam int PER_W       = PPC_W + 16;
    localparam int NUM_W       = RW + PER_W;
    localparam int SUM_W       = NUM_W + 1;
    localparam int TL_W        = $clog2(ZERO_CROSSINGS * PHASES_PER_CROSSING + 1) + 16;
    localparam int P_W         = TL_W + 1;
    localparam int PM_W        = PER_W + CW;
    localparam int ACC_W       = 26 + $clog2(RING_DEPTH);
    localparam int SH_W        = ACC_W - 8;
    localparam int SC_W        = SH_W + CW + 1;
    localparam int Y_W         = SC_W - 16;

    localparam logic [PER_W-1:0] PERIOD_IN  = PER_W'(PHASES_PER_CROSSING) << 16;
    localparam logic [P_W-1:0]   TIME_LIMIT =
        P_W'(ZERO_CROSSINGS * PHASES_PER_CROSSING) << 16;
    localparam logic [TW-1:0]    T_RESET    =
        TW'(PHASES_PER_CROSSING * (HALF_TAPS + 1)) << 16;
    localparam logic [TW-1:0]    PHASE_MAX  = {TW{1'b1}};

    // Rates and derived step sizes.
    logic [RW-1:0]    fin_reg, fout_reg, fin_c, fout_c;
    logic             cfg_ok;
    logic [CW-1:0]    cut_reg;
    logic [NUM_W-1:0] tout_reg;
    logic [PER_W-1:0] dt_reg;
    logic [NUM_W-1:0] div_num, div_quot;
    logic [RW-1:0]    div_den;
    logic             div_busy;

    // Phase and ring bookkeeping.
    logic [TW-1:0]         t_reg, t_next;
    logic [SUM_W-1:0]      t_sum;
    logic [PER_W-1:0]      t_low, mul_src;
    logic [RING_AW-1:0]    ring_pos_reg;
    logic [RING_DEPTH-1:0] ring_valid_reg;
    logic [RING_AW:0]      start_b, start_f;
    logic [RING_AW-1:0]    start_b_m, start_f_m;

    // Tap walk.
    logic [PM_W-1:0]    pmul_reg;
    logic [P_W-1:0]     p_reg;
    logic [RING_AW-1:0] k_reg, k_step;
    logic               tab_wr;

    // Tap pipeline.
    logic [SW-1:0]           ring_rd;
    logic [2*SW-1:0]         tab_rd;
    logic                    v1_reg, v2_reg, v3_reg, rv1_reg;
    logic [15:0]             frac1_reg;
    logic signed [SW-1:0]    samp2_reg, base2_reg, coef3;
    logic signed [2*SW:0]    sprod2_reg;
    logic signed [2*SW-1:0]  m3_reg;
    logic signed [24:0]      term3;
    logic signed [ACC_W-1:0] acc_reg, rnd_reg, rnd_add;
    logic signed [SH_W-1:0]  shv;
    logic signed [SC_W-1:0]  scl_reg, scl_next;
    logic signed [Y_W-1:0]   y_full;
    logic signed [SW-1:0]    y_sat;

    // Output register.
    logic                 out_valid_reg;
    logic signed [SW-1:0] sample_out_reg;
    logic                 last_reg;

    // A rate write is kept only if it is non-zero and leaves the upsampling ratio at 64 or less.
    always_comb
    begin
        fin_c  = (cfg_index == wsr_pkg::REG_INPUT_RATE)  ? cfg_data : fin_reg;
        fout_c = (cfg_index == wsr_pkg::REG_OUTPUT_RATE) ? cfg_data : fout_reg;
        cfg_ok = cmd.cfg_write && (cfg_data != '0) &&
                 ((cfg_index == wsr_pkg::REG_INPUT_RATE) ||
                  (cfg_index == wsr_pkg::REG_OUTPUT_RATE)) &&
                 !({{wsr_pkg::UPSAMPLE_SH{1'b0}}, fout_c} >
                   {fin_c, {wsr_pkg::UPSAMPLE_SH{1'b0}}});
    end

    always_comb
    begin
        div_num = cmd.div_sel ? ((NUM_W'(fin_reg) * NUM_W'(PHASES_PER_CROSSING)) << 16)
                              : NUM_W'({fout_reg, 16'h0000});
        div_den = cmd.div_sel ? fout_reg : fin_reg;
    end

    wsr_divider #(
        .NUM_W (NUM_W),
        .DEN_W (RW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg  <= wsr_pkg::RATE_RESET;
            fout_reg <= wsr_pkg::RATE_RESET;
        end
        else if (cfg_ok)
        begin
            fin_reg  <= fin_c;
            fout_reg <= fout_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cut_cap)
        begin
            cut_reg <= (fin_reg < fout_reg) ? wsr_pkg::UNIT_ONE : div_quot[CW-1:0];
        end
        if (cmd.tout_cap)
        begin
            tout_reg <= div_quot;
            dt_reg   <= PER_W'(32'(cut_reg) * PHASES_PER_CROSSING);
        end
    end

    // Phase: a push moves it back one input period, each output moves it on one output period.
    always_comb
    begin
        t_sum  = SUM_W'(t_reg) + SUM_W'(tout_reg);
        t_next = t_reg;
        if (cmd.push)
        begin
            t_next = (t_reg >= TW'(PERIOD_IN)) ? (t_reg - TW'(PERIOD_IN)) : '0;
        end
        else if (cmd.emit)
        begin
            t_next = (t_sum > SUM_W'(PHASE_MAX)) ? PHASE_MAX : t_sum[TW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg          <= T_RESET;
            ring_pos_reg   <= '0;
            ring_valid_reg <= '0;
        end
        else
        begin
            t_reg <= t_next;
            if (cmd.push)
            begin
                ring_valid_reg[ring_pos_reg] <= 1'b1;
                ring_pos_reg <= (ring_pos_reg == RING_AW'(RING_DEPTH - 1)) ?
                                '0 : ring_pos_reg + 1'b1;
            end
        end
    end

    // Start points of the backward and forward walks.
    always_comb
    begin
        t_low     = t_reg[PER_W-1:0];
        mul_src   = cmd.dir_fwd ? (PERIOD_IN - t_low) : t_low;
        start_b   = (RING_AW+1)'(ring_pos_reg) + (RING_AW+1)'(HALF_TAPS);
        start_f   = (RING_AW+1)'(ring_pos_reg) + (RING_AW+1)'(HALF_TAPS + 1);
        start_b_m = (start_b >= (RING_AW+1)'(RING_DEPTH)) ?
                    RING_AW'(start_b - (RING_AW+1)'(RING_DEPTH)) : start_b[RING_AW-1:0];
        start_f_m = (start_f >= (RING_AW+1)'(RING_DEPTH)) ?
                    RING_AW'(start_f - (RING_AW+1)'(RING_DEPTH)) : start_f[RING_AW-1:0];
        if (cmd.dir_fwd)
        begin
            k_step = (k_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : k_reg + 1'b1;
        end
        else
        begin
            k_step = (k_reg == '0) ? RING_AW'(RING_DEPTH - 1) : k_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p_mul)
        begin
            pmul_reg <= PM_W'(mul_src) * PM_W'(cut_reg);
        end
        if (cmd.p_load)
        begin
            p_reg <= P_W'(pmul_reg >> 16);
            k_reg <= cmd.dir_fwd ? start_f_m : start_b_m;
        end
        else if (cmd.tap_issue)
        begin
            p_reg <= p_reg + P_W'(dt_reg);
            k_reg <= k_step;
        end
    end

    assign tab_wr = cmd.tab_write && (32'(table_index) < TABLE_DEPTH);

    wsr_ram #(
        .WIDTH (SW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (ring_pos_reg),
        .wr_data (sample_in),
        .rd_addr (k_reg),
        .rd_data (ring_rd)
    );

    wsr_ram #(
        .WIDTH (2 * SW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (tab_wr),
        .wr_addr (TAB_AW'(table_index)),
        .wr_data ({coef_base, coef_slope}),
        .rd_addr (p_reg[16 +: TAB_AW]),
        .rd_data (tab_rd)
    );

    // Tap pipeline: table and ring read, slope interpolation, sample product, accumulate.
    always_comb
    begin
        coef3 = base2_reg + SW'(sprod2_reg >>> 16);
        term3 = 25'(m3_reg >>> 7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.tap_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rv1_reg    <= ring_valid_reg[k_reg];
        frac1_reg  <= p_reg[wsr_pkg::FRAC_W-1:0];
        samp2_reg  <= rv1_reg ? $signed(ring_rd) : '0;
        base2_reg  <= $signed(tab_rd[2*SW-1:SW]);
        sprod2_reg <= $signed(tab_rd[SW-1:0]) * $signed({1'b0, frac1_reg});
        m3_reg     <= samp2_reg * coef3;
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(term3);
        end
    end

    // Rounding, cutoff scaling and saturation.
    always_comb
    begin
        rnd_add  = acc_reg[7] ? ACC_W'(wsr_pkg::RND_BIAS) : '0;
        shv      = $signed(rnd_reg[ACC_W-1:8]);
        scl_next = SC_W'(shv) * $signed(SC_W'({1'b0, cut_reg}));
        y_full   = $signed(scl_reg[SC_W-1:16]);
        if (y_full > Y_W'(32767))
        begin
            y_sat = 16'sh7fff;
        end
        else if (y_full < -Y_W'(32768))
        begin
            y_sat = -16'sh8000;
        end
        else
        begin
            y_sat = SW'(y_full);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rnd)
        begin
            rnd_reg <= acc_reg + rnd_add;
        end
        if (cmd.scale)
        begin
            scl_reg <= scl_next;
        end
        if (cmd.emit)
        begin
            sample_out_reg <= y_sat;
            last_reg       <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.div_busy    = div_busy;
    assign status.t_lt_period = t_reg < TW'(PERIOD_IN);
    assign status.p_ok        = p_reg <= TIME_LIMIT;
    assign status.pipe_empty  = !v1_reg && !v2_reg && !v3_reg;
    assign status.out_free    = !out_valid_reg || !out_stall;
    assign status.tnext_lt    = t_sum < SUM_W'(PERIOD_IN);

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign last_of_run = last_reg;

endmodule

@@ verif/wsr_checker.sv @@
// Beat monitor, output predictor and scoreboard for the windowed-sinc rate converter.
module wsr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [wsr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wsr_pkg::RATE_W-1:0]          cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                operation,
    input  logic [wsr_pkg::TAB_IDX_W-1:0]       table_index,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] coef_base,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] coef_slope,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [wsr_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                last_of_run,
    output int                                  fail_count,
    output int                                  pending
);

    localparam int     SW      = wsr_pkg::SAMPLE_W;
    localparam int     HALF    = 32;
    localparam int     DEPTH   = 2 * HALF + 1;
    localparam int     TAB_LEN = 16 * 256 + 1;
    localparam longint PERIOD  = longint'(256) << 16;
    localparam longint T_LIMIT = 16 * PERIOD;
    localparam longint T_MAX   = (longint'(1) << 40) - 1;

    typedef struct {
        logic signed [SW-1:0] value;
        logic                 last;
    } out_sample_t;

    out_sample_t          due_samples[$];
    logic signed [SW-1:0] history[0:DEPTH-1];
    logic signed [SW-1:0] tab_base[0:TAB_LEN-1];
    logic signed [SW-1:0] tab_slope[0:TAB_LEN-1];
    int                   hist_pos;
    longint               phase;
    longint               rate_in;
    longint               rate_out;

    function automatic longint coef_lookup(longint p);
        longint               idx;
        longint               sum;
        logic signed [SW-1:0] wrapped;
        idx = p >> 16;
        if (idx >= TAB_LEN)
            idx = TAB_LEN - 1;
        sum = longint'(tab_base[idx])
            + ((longint'(tab_slope[idx]) * (p & 64'hffff)) >>> 16);
        wrapped = sum[SW-1:0];
        return longint'(wrapped);
    endfunction

    function automatic longint filter_output(longint t, longint cut);
        longint dt;
        longint p;
        longint acc;
        int     i;
        dt  = (PERIOD * cut) >> 16;
        acc = 0;
        p   = (t * cut) >> 16;
        for (i = 0; i <= HALF && p <= T_LIMIT; i++)
        begin
            acc += (longint'(history[(hist_pos + HALF - i) % DEPTH]) * coef_lookup(p)) >>> 7;
            p += dt;
        end
        p = ((PERIOD - t) * cut) >> 16;
        for (i = 1; i <= HALF && p <= T_LIMIT; i++)
        begin
            acc += (longint'(history[(hist_pos + HALF + i) % DEPTH]) * coef_lookup(p)) >>> 7;
            p += dt;
        end
        if (acc[7])
            acc += 127;
        acc = ((acc >>> 8) * cut) >>> 16;
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        return acc;
    endfunction

    function automatic void predict_push(logic signed [SW-1:0] smp);
        longint      cut;
        longint      step;
        longint      t;
        longint      y;
        int          n;
        out_sample_t item;
        cut  = (rate_in < rate_out) ? 65536 : (rate_out * 65536) / rate_in;
        step = (PERIOD * rate_in) / rate_out;
        history[hist_pos] = smp;
        hist_pos = (hist_pos + 1) % DEPTH;
        t = (phase >= PERIOD) ? phase - PERIOD : 0;
        n = 0;
        while (t < PERIOD && n < wsr_pkg::MAX_OUTPUTS)
        begin
            y = filter_output(t, cut);
            item.value = y[SW-1:0];
            item.last  = 1'b0;
            due_samples.push_back(item);
            n++;
            t += step;
            if (t > T_MAX)
                t = T_MAX;
        end
        if (n > 0)
            due_samples[due_samples.size()-1].last = 1'b1;
        phase = t;
    endfunction

    function automatic void apply_rate(logic [wsr_pkg::CFG_IDX_W-1:0] idx, longint value);
        longint fin;
        longint fout;
        fin  = rate_in;
        fout = rate_out;
        if (value == 0)
            return;
        if (idx == wsr_pkg::REG_INPUT_RATE)
            fin = value;
        else if (idx == wsr_pkg::REG_OUTPUT_RATE)
            fout = value;
        else
            return;
        if (fout > wsr_pkg::MAX_OUTPUTS * fin)
            return;
        rate_in  = fin;
        rate_out = fout;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (history[i])
                history[i] = '0;
            hist_pos = 0;
            phase    = (longint'(256) * (HALF + 1)) << 16;
            rate_in  = wsr_pkg::RATE_RESET;
            rate_out = wsr_pkg::RATE_RESET;
            due_samples.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_samples.size() == 0)
                begin
                    $error("sample_out: unexpected beat, actual %0d", sample_out);
                    fail_count++;
                end
                else
                begin
                    if (sample_out !== due_samples[0].value)
                    begin
                        $error("sample_out: expected %0d, actual %0d",
                               due_samples[0].value, sample_out);
                        fail_count++;
                    end
                    if (last_of_run !== due_samples[0].last)
                    begin
                        $error("last_of_run: expected %0b, actual %0b",
                               due_samples[0].last, last_of_run);
                        fail_count++;
                    end
                    void'(due_samples.pop_front());
                end
            end
            if (cfg_valid && cfg_ready)
                apply_rate(cfg_index, longint'(cfg_data));
            if (in_valid && !in_stall)
            begin
                if (operation == wsr_pkg::OP_LOAD)
                begin
                    if (table_index < TAB_LEN)
                    begin
                        tab_base[table_index]  = coef_base;
                        tab_slope[table_index] = coef_slope;
                    end
                end
                else
                    predict_push(sample_in);
            end
            pending = due_samples.size();
        end
    end

endmodule

@@ verif/windowed_sinc_resampler_test.sv @@
// Stimulus and verdict for the windowed-sinc sample rate converter.
module windowed_sinc_resampler_test;

    localparam int CW  = wsr_pkg::CFG_IDX_W;
    localparam int RW  = wsr_pkg::RATE_W;
    localparam int TIW = wsr_pkg::TAB_IDX_W;
    localparam int SW  = wsr_pkg::SAMPLE_W;

    // Indexes outside the register map; writes to them must be dropped.
    localparam logic [CW-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CW-1:0] REG_SPARE_B = 2'd3;
    localparam int TABLE_LEN = 16 * 256 + 1;
    // Cycles allowed for a push that makes no output, or a division, to finish.
    localparam int SETTLE = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CW-1:0]        cfg_index;
    logic [RW-1:0]        cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 operation;
    logic [TIW-1:0]       table_index;
    logic signed [SW-1:0] coef_base;
    logic signed [SW-1:0] coef_slope;
    logic signed [SW-1:0] sample_in;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [SW-1:0] sample_out;
    logic                 last_of_run;
    int                   fail_count;
    int                   pending;

    // Set for the closing stretch, during which neither side idles.
    bit     calm;
    int     out_beats;
    longint cur_in;
    longint cur_out;

    windowed_sinc_resampler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .table_index (table_index),
        .coef_base   (coef_base),
        .coef_slope  (coef_slope),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .last_of_run (last_of_run)
    );

    wsr_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .table_index (table_index),
        .coef_base   (coef_base),
        .coef_slope  (coef_slope),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .last_of_run (last_of_run),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset is applied once and released on a falling edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
    end

    // The slowest correct run ends well before this timeout.
    initial
    begin
        #200000000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
        if (out_valid && !out_stall)
            out_beats++;

    // Output side. Short random stalls, plus one long hold-off early on while the
    // sender keeps offering samples, so that the block backs up and stalls its input.
    initial
    begin
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && out_beats >= 40)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (1500) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one input beat and returns on the falling edge after it was taken.
    // Valid is left high; back-to-back beats lower it in between only for a random gap.
    task automatic send_beat(logic op, logic [TIW-1:0] idx,
                             logic signed [SW-1:0] base,
                             logic signed [SW-1:0] slope,
                             logic signed [SW-1:0] smp);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        table_index <= idx;
        coef_base   <= base;
        coef_slope  <= slope;
        sample_in   <= smp;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic push_sample(logic signed [SW-1:0] smp);
        send_beat(wsr_pkg::OP_PUSH, TIW'($urandom), SW'($urandom),
                  SW'($urandom), smp);
    endtask

    // Waits until every predicted output has arrived, then lets any push that
    // produced nothing drain before the block is treated as idle.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [CW-1:0] idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[RW-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        // Only a write that keeps the ratio legal takes effect.
        if (value != 0 && idx == wsr_pkg::REG_INPUT_RATE &&
            cur_out <= wsr_pkg::MAX_OUTPUTS * value)
            cur_in = value;
        else if (value != 0 && idx == wsr_pkg::REG_OUTPUT_RATE &&
                 value <= wsr_pkg::MAX_OUTPUTS * cur_in)
            cur_out = value;
    endtask

    // Moves to a new rate pair; the order of the two writes keeps each step legal.
    task automatic set_rates(longint fin, longint fout);
        drain();
        if (fout <= wsr_pkg::MAX_OUTPUTS * cur_in)
        begin
            write_reg(wsr_pkg::REG_OUTPUT_RATE, fout);
            write_reg(wsr_pkg::REG_INPUT_RATE, fin);
        end
        else
        begin
            write_reg(wsr_pkg::REG_INPUT_RATE, fin);
            write_reg(wsr_pkg::REG_OUTPUT_RATE, fout);
        end
    endtask

    // A phase of random traffic: mostly samples, with a sprinkling of table loads
    // that may land anywhere, including past the end of the table.
    task automatic random_run(int pushes);
        int k;
        k = 0;
        while (k < pushes)
        begin
            if ($urandom_range(0, 9) == 0)
                send_beat(wsr_pkg::OP_LOAD, TIW'($urandom), SW'($urandom),
                          SW'($urandom), SW'($urandom));
            else
            begin
                case ($urandom_range(0, 7))
                    0:       push_sample(16'sh7fff);
                    1:       push_sample(-16'sh8000);
                    default: push_sample(SW'($urandom));
                endcase
                k++;
            end
        end
    endtask

    initial
    begin
        int i;
        calm        = 1'b0;
        out_beats   = 0;
        cur_in      = wsr_pkg::RATE_RESET;
        cur_out     = wsr_pkg::RATE_RESET;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        operation   = wsr_pkg::OP_LOAD;
        table_index = '0;
        coef_base   = '0;
        coef_slope  = '0;
        sample_in   = '0;
        @(posedge rst_n);
        @(negedge clk);

        // Fill the whole table first, so no push can read an unwritten entry.
        // Modest values keep most outputs clear of saturation.
        for (i = 0; i < TABLE_LEN; i++)
            send_beat(wsr_pkg::OP_LOAD, TIW'(i),
                      SW'($urandom_range(0, 2047) - 1024),
                      SW'($urandom_range(0, 511) - 256),
                      SW'($urandom));

        // Directed beats: extreme entries, where base plus slope wraps, loads past
        // the end of the table that must be dropped, and extreme samples.
        send_beat(wsr_pkg::OP_LOAD, 13'd0, 16'sh7fff, 16'sh7fff, 16'sh0000);
        send_beat(wsr_pkg::OP_LOAD, 13'd4096, -16'sh8000, -16'sh8000, -16'sh0001);
        send_beat(wsr_pkg::OP_LOAD, 13'd4097, 16'sh1234, 16'sh4321, 16'sh0000);
        send_beat(wsr_pkg::OP_LOAD, 13'h1fff, -16'sh0001, -16'sh0001, -16'sh0001);
        push_sample(16'sh7fff);
        push_sample(-16'sh8000);
        push_sample(16'sh0000);
        push_sample(-16'sh0001);
        push_sample(16'sh0001);
        for (i = 0; i < 15; i++)
            push_sample(i[0] ? 16'sh7fff : -16'sh8000);

        // Unity ratio at reset rates; the first outputs only appear once the
        // history has filled, and the long output hold-off falls in here.
        random_run(150);

        set_rates(44100, 48000);
        random_run(70);

        set_rates(48000, 44100);
        random_run(60);

        set_rates(96000, 32000);
        random_run(50);

        set_rates(16777215, 16777215);
        random_run(40);

        // Exactly the largest upsampling ratio, then writes the block must drop:
        // one past that ratio, a zero rate, and indexes outside the map.
        set_rates(100, 6400);
        write_reg(wsr_pkg::REG_OUTPUT_RATE, 6401);
        write_reg(wsr_pkg::REG_INPUT_RATE, 0);
        write_reg(wsr_pkg::REG_OUTPUT_RATE, 0);
        write_reg(REG_SPARE_A, 1000);
        write_reg(REG_SPARE_B, 16777215);
        random_run(15);

        set_rates(1, 64);
        random_run(10);

        // Closing stretch without idling on either side: the steepest downsampling,
        // where the cutoff falls to zero and the time saturates. Left for last, as
        // the saturated time would hold off outputs for any later phase.
        set_rates(16777215, 1);
        calm = 1'b1;
        random_run(20);

        drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
